@@ rtl/core/tehs_pkg.sv @@
`default_nettype none

package tehs_pkg;

   // Defaults for the top-level parameters
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int ID_COUNT_DEF    = 64;

   // Fixed field widths
   localparam int ID_W   = 6;
   localparam int TIME_W = 64;
   localparam int ST_W   = 2;

   // Ids that fit the id field; the position table never needs more
   localparam int ID_SLOTS = 1 << ID_W;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_PAST  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Heap slot selected for a read
   typedef enum logic [2:0] {
      RA_NONE,
      RA_PARENT,
      RA_LEFT,
      RA_RIGHT,
      RA_ROOT,
      RA_LAST
   } rdaddr_type;

   // Source of the fired id on the response word
   typedef enum logic [1:0] {
      FS_ID,
      FS_ZERO,
      FS_POP
   } fsel_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] key;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      rdaddr_type heap_rd;
      logic       pos_rd;
      logic       hole_pos;
      logic       grow;
      logic       mv_up;
      logic       latch_left;
      logic       mv_down;
      logic       place;
      logic       set_now;
      logic       pop_fire;
      logic       pop_mid;
      logic       emit;
      status_type status;
      fsel_type   fsel;
      logic       last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op;
      logic err_time;
      logic err_id;
      logic pend;
      logic full;
      logic empty;
      logic hole_root;
      logic up_go;
      logic rs_down;
      logic dn_end;
      logic right_ok;
      logic dn_stop;
      logic top_eq;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/core/tehs_ctrl.sv @@
`default_nettype none

module tehs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire tehs_pkg::stat_type st,
   output tehs_pkg::cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_POS_W,
      S_RS_RD,
      S_RS_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_DN_L,
      S_DN_R,
      S_DN_C,
      S_PLACE,
      S_TK_NOW,
      S_POP,
      S_POP_M,
      S_TK_CHK,
      S_TK_CMP,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   tehs_pkg::status_type sts_ff, sts_in;
   tehs_pkg::fsel_type   fsel_ff, fsel_in;
   logic                 last_ff, last_in;

   assign req_stall = (state_ff != S_IDLE);

   // Sequencing and micro-commands
   always_comb begin
      cmd        = '0;
      cmd.status = sts_ff;
      cmd.fsel   = fsel_ff;
      cmd.last   = last_ff;
      state_in   = state_ff;
      sts_in     = sts_ff;
      fsel_in    = fsel_ff;
      last_in    = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            fsel_in = tehs_pkg::FS_ID;
            last_in = 1'b1;
            if (!st.op) begin
               if (st.err_time) begin
                  sts_in   = tehs_pkg::ST_PAST;
                  state_in = S_EMIT;
               end else if (st.err_id) begin
                  sts_in   = tehs_pkg::ST_FULL;
                  state_in = S_EMIT;
               end else if (!st.pend) begin
                  if (st.full) begin
                     sts_in   = tehs_pkg::ST_FULL;
                     state_in = S_EMIT;
                  end else begin
                     cmd.grow = 1'b1;
                     state_in = S_UP_RD;
                  end
               end else begin
                  cmd.pos_rd = 1'b1;
                  state_in   = S_POS_W;
               end
            end else if (st.empty) begin
               sts_in   = tehs_pkg::ST_EMPTY;
               fsel_in  = tehs_pkg::FS_ZERO;
               state_in = S_EMIT;
            end else begin
               cmd.heap_rd = tehs_pkg::RA_ROOT;
               state_in    = S_TK_NOW;
            end
         end
         S_POS_W: begin
            cmd.hole_pos = 1'b1;
            state_in     = S_RS_RD;
         end
         S_RS_RD: begin
            if (st.hole_root) begin
               state_in = S_DN_L;
            end else begin
               cmd.heap_rd = tehs_pkg::RA_PARENT;
               state_in    = S_RS_CMP;
            end
         end
         S_RS_CMP: begin
            // parent is already read: reuse it for the first sift-up compare
            state_in = st.rs_down ? S_DN_L : S_UP_CMP;
         end
         S_UP_RD: begin
            if (st.hole_root) begin
               state_in = S_PLACE;
            end else begin
               cmd.heap_rd = tehs_pkg::RA_PARENT;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (st.up_go) begin
               cmd.mv_up = 1'b1;
               state_in  = S_UP_RD;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_DN_L: begin
            if (st.dn_end) begin
               state_in = S_PLACE;
            end else begin
               cmd.heap_rd = tehs_pkg::RA_LEFT;
               state_in    = S_DN_R;
            end
         end
         S_DN_R: begin
            cmd.latch_left = 1'b1;
            if (st.right_ok) begin
               cmd.heap_rd = tehs_pkg::RA_RIGHT;
            end
            state_in = S_DN_C;
         end
         S_DN_C: begin
            if (st.dn_stop) begin
               state_in = S_PLACE;
            end else begin
               cmd.mv_down = 1'b1;
               state_in    = S_DN_L;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            if (!st.op) begin
               sts_in   = tehs_pkg::ST_OK;
               fsel_in  = tehs_pkg::FS_ID;
               last_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_TK_CHK;
            end
         end
         S_TK_NOW: begin
            cmd.set_now = 1'b1;
            state_in    = S_POP;
         end
         S_POP: begin
            cmd.pop_fire = 1'b1;
            cmd.heap_rd  = tehs_pkg::RA_LAST;
            state_in     = S_POP_M;
         end
         S_POP_M: begin
            cmd.pop_mid = 1'b1;
            state_in    = st.empty ? S_TK_CHK : S_DN_L;
         end
         S_TK_CHK: begin
            sts_in  = tehs_pkg::ST_OK;
            fsel_in = tehs_pkg::FS_POP;
            if (st.empty) begin
               last_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.heap_rd = tehs_pkg::RA_ROOT;
               state_in    = S_TK_CMP;
            end
         end
         S_TK_CMP: begin
            // another id due now keeps the run going
            last_in  = !st.top_eq;
            state_in = S_EMIT;
         end
         default: begin
            if (st.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = last_ff ? S_IDLE : S_POP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sts_ff   <= tehs_pkg::ST_OK;
         fsel_ff  <= tehs_pkg::FS_ID;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sts_ff   <= sts_in;
         fsel_ff  <= fsel_in;
         last_ff  <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tehs_dpath.sv @@
`default_nettype none

module tehs_dpath #(
   parameter int QUEUE_DEPTH = tehs_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_COUNT    = tehs_pkg::ID_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tehs_pkg::cmd_type           cmd,
   output tehs_pkg::stat_type               st,
   input  wire logic                        req_opcode,
   input  wire logic [tehs_pkg::ID_W-1:0]   req_item_id,
   input  wire logic [tehs_pkg::TIME_W-1:0] req_event_time,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [tehs_pkg::ST_W-1:0]        rsp_status,
   output logic [tehs_pkg::ID_W-1:0]        rsp_fired_id,
   output logic [tehs_pkg::TIME_W-1:0]      rsp_current_time,
   output logic                             rsp_last_of_run
);

   localparam int SW  = $clog2(QUEUE_DEPTH + 1);
   localparam int AW  = $clog2(QUEUE_DEPTH);
   localparam int PD  = (ID_COUNT < tehs_pkg::ID_SLOTS) ? ID_COUNT : tehs_pkg::ID_SLOTS;
   localparam int PIW = $clog2(PD);

   // Item registers
   logic                          op_ff;
   logic [tehs_pkg::ID_W-1:0]     id_ff;
   logic [tehs_pkg::TIME_W-1:0]   key_ff;
   logic [tehs_pkg::TIME_W-1:0]   now_ff;
   logic [SW-1:0]                 count_ff;
   logic [SW-1:0]                 hole_ff;
   tehs_pkg::entry_type           left_ff;
   logic [tehs_pkg::ID_W-1:0]     fired_ff;
   logic [PD-1:0]                 pend_ff;

   // Heap store and position table
   tehs_pkg::entry_type           heap_mem [QUEUE_DEPTH];
   tehs_pkg::entry_type           heap_q;
   logic [SW-1:0]                 pos_mem [PD];
   logic [SW-1:0]                 pos_q;

   // Response word
   logic                          rsp_valid_ff;
   tehs_pkg::status_type          rsp_status_ff;
   logic [tehs_pkg::ID_W-1:0]     rsp_id_ff;
   logic [tehs_pkg::TIME_W-1:0]   rsp_time_ff;
   logic                          rsp_last_ff;

   logic [SW:0]                   child;
   logic [SW:0]                   child_r;
   logic                          right_ok;
   logic                          use_r;
   tehs_pkg::entry_type           chosen;
   logic [SW:0]                   cslot;
   logic [SW:0]                   rslot;
   logic [AW-1:0]                 raddr;
   logic                          heap_we;
   logic [AW-1:0]                 waddr;
   tehs_pkg::entry_type           wdata;
   logic [PIW-1:0]                paddr;

   // Child selection for sift-down
   assign child    = {hole_ff, 1'b0};
   assign child_r  = child + 1'b1;
   assign right_ok = (child_r <= {1'b0, count_ff});
   assign use_r    = right_ok && (heap_q.key < left_ff.key);
   assign chosen   = use_r ? heap_q : left_ff;
   assign cslot    = use_r ? child_r : child;

   // Read slot
   always_comb begin
      case (cmd.heap_rd)
         tehs_pkg::RA_PARENT: rslot = {2'b00, hole_ff[SW-1:1]};
         tehs_pkg::RA_LEFT:   rslot = child;
         tehs_pkg::RA_RIGHT:  rslot = child_r;
         tehs_pkg::RA_ROOT:   rslot = (SW+1)'(1);
         tehs_pkg::RA_LAST:   rslot = {1'b0, count_ff};
         default:             rslot = (SW+1)'(1);
      endcase
   end
   assign raddr = AW'(rslot - 1'b1);

   // Write port
   always_comb begin
      heap_we = cmd.mv_up || cmd.mv_down || cmd.place;
      waddr   = AW'(hole_ff - 1'b1);
      if (cmd.mv_up) begin
         wdata = heap_q;
      end else if (cmd.mv_down) begin
         wdata = chosen;
      end else begin
         wdata = '{id: id_ff, key: key_ff};
      end
   end
   assign paddr = wdata.id[PIW-1:0];

   // Status to controller
   assign st.op        = op_ff;
   assign st.err_time  = (key_ff <= now_ff) || (&key_ff);
   assign st.err_id    = (32'(id_ff) >= 32'(ID_COUNT));
   assign st.pend      = pend_ff[id_ff[PIW-1:0]];
   assign st.full      = (count_ff == SW'(QUEUE_DEPTH));
   assign st.empty     = (count_ff == '0);
   assign st.hole_root = (hole_ff == SW'(1));
   assign st.up_go     = (key_ff < heap_q.key);
   assign st.rs_down   = (heap_q.key < key_ff);
   assign st.dn_end    = (child > {1'b0, count_ff});
   assign st.right_ok  = right_ok;
   assign st.dn_stop   = (key_ff < chosen.key);
   assign st.top_eq    = (heap_q.key == now_ff);
   assign st.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Memories
   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[waddr] <= wdata;
         pos_mem[paddr]  <= hole_ff;
      end
      if (cmd.heap_rd != tehs_pkg::RA_NONE) begin
         heap_q <= heap_mem[raddr];
      end
      if (cmd.pos_rd) begin
         pos_q <= pos_mem[id_ff[PIW-1:0]];
      end
   end

   // Item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         id_ff  <= req_item_id;
         key_ff <= req_event_time;
      end else if (cmd.pop_mid) begin
         id_ff  <= heap_q.id;
         key_ff <= heap_q.key;
      end
      if (cmd.latch_left) begin
         left_ff <= heap_q;
      end
      if (cmd.pop_fire) begin
         fired_ff <= heap_q.id;
      end
      if (cmd.grow) begin
         hole_ff <= count_ff + 1'b1;
      end else if (cmd.hole_pos) begin
         hole_ff <= pos_q;
      end else if (cmd.mv_up) begin
         hole_ff <= hole_ff >> 1;
      end else if (cmd.mv_down) begin
         hole_ff <= SW'(cslot);
      end else if (cmd.pop_mid) begin
         hole_ff <= SW'(1);
      end
   end

   // Queue state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         now_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         if (cmd.grow) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop_fire) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.set_now) begin
            now_ff <= heap_q.key;
         end
         if (cmd.place && !op_ff) begin
            pend_ff[id_ff[PIW-1:0]] <= 1'b1;
         end
         if (cmd.pop_fire) begin
            pend_ff[heap_q.id[PIW-1:0]] <= 1'b0;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_time_ff   <= now_ff;
         rsp_last_ff   <= cmd.last;
         case (cmd.fsel)
            tehs_pkg::FS_ID:  rsp_id_ff <= id_ff;
            tehs_pkg::FS_POP: rsp_id_ff <= fired_ff;
            default:          rsp_id_ff <= '0;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired_id     = rsp_id_ff;
   assign rsp_current_time = rsp_time_ff;
   assign rsp_last_of_run  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SW'(QUEUE_DEPTH))
      else $error("heap count beyond depth");

   a_place_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> (hole_ff != '0) && (hole_ff <= count_ff))
      else $error("placement outside live heap");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_fire |=> count_ff == SW'($past(count_ff) - 1'b1))
      else $error("pop did not shrink heap");
`endif

endmodule

`default_nettype wire

@@ rtl/core/timed_event_heap_scheduler.sv @@
// Timing: a schedule takes longer for each heap level the item climbs or sinks, and a
// reject or an empty tick goes straight from decode to the response; a tick takes longer
// for each fired id and each level sunk; a stalled output adds its wait.
// Throughput: one item at a time; the single heap read port sets the per-level cost.
// Next item is taken once the last response word has entered the output register.
// Reset (synchronous, active high) empties the queue and sets current time to zero.
`default_nettype none

module timed_event_heap_scheduler #(
   parameter int QUEUE_DEPTH = tehs_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_COUNT    = tehs_pkg::ID_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_opcode,
   input  wire logic [tehs_pkg::ID_W-1:0]   req_item_id,
   input  wire logic [tehs_pkg::TIME_W-1:0] req_event_time,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [tehs_pkg::ST_W-1:0]        rsp_status,
   output logic [tehs_pkg::ID_W-1:0]        rsp_fired_id,
   output logic [tehs_pkg::TIME_W-1:0]      rsp_current_time,
   output logic                             rsp_last_of_run
);

   tehs_pkg::cmd_type  cmd;
   tehs_pkg::stat_type st;

   tehs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tehs_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_COUNT    (ID_COUNT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_opcode       (req_opcode),
      .req_item_id      (req_item_id),
      .req_event_time   (req_event_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_fired_id     (rsp_fired_id),
      .rsp_current_time (rsp_current_time),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ tb/heap_sched_checker.sv @@
`timescale 1ns / 1ps

module heap_sched_checker #(
   parameter int QUEUE_DEPTH = tehs_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_COUNT    = tehs_pkg::ID_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic                        req_opcode,
   input  wire logic [tehs_pkg::ID_W-1:0]   req_item_id,
   input  wire logic [tehs_pkg::TIME_W-1:0] req_event_time,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire logic [tehs_pkg::ST_W-1:0]   rsp_status,
   input  wire logic [tehs_pkg::ID_W-1:0]   rsp_fired_id,
   input  wire logic [tehs_pkg::TIME_W-1:0] rsp_current_time,
   input  wire logic                        rsp_last_of_run,
   output int                               fail_count,
   output int                               words_owed
);

   localparam logic [tehs_pkg::TIME_W-1:0] NEVER = '1;

   typedef struct packed {
      tehs_pkg::status_type          status;
      logic [tehs_pkg::ID_W-1:0]     id;
      logic [tehs_pkg::TIME_W-1:0]   now;
      logic                          last;
   } fire_word_type;

   // Shadow copy of the scheduler state
   logic [tehs_pkg::ID_W-1:0]   slot_id  [1:QUEUE_DEPTH];
   logic [tehs_pkg::TIME_W-1:0] slot_key [1:QUEUE_DEPTH];
   int                          id_slot  [tehs_pkg::ID_SLOTS];
   logic [tehs_pkg::TIME_W-1:0] due_time [tehs_pkg::ID_SLOTS];
   int                          live;
   logic [tehs_pkg::TIME_W-1:0] clock_now;

   fire_word_type expected_words[$];

   assign words_owed = expected_words.size();

   function automatic void place_entry(int s, logic [tehs_pkg::ID_W-1:0] id,
                                       logic [tehs_pkg::TIME_W-1:0] k);
      slot_id[s] = id;
      slot_key[s] = k;
      id_slot[id] = s;
   endfunction

   function automatic int climb(int hole, logic [tehs_pkg::TIME_W-1:0] k);
      while (hole > 1 && k < slot_key[hole/2]) begin
         place_entry(hole, slot_id[hole/2], slot_key[hole/2]);
         hole = hole / 2;
      end
      return hole;
   endfunction

   function automatic int sink(int hole, logic [tehs_pkg::TIME_W-1:0] k);
      int c;
      forever begin
         c = hole * 2;
         if (c > live) break;
         if (c + 1 <= live && slot_key[c+1] < slot_key[c]) c++;
         if (k < slot_key[c]) break;
         place_entry(hole, slot_id[c], slot_key[c]);
         hole = c;
      end
      return hole;
   endfunction

   function automatic void push_word(tehs_pkg::status_type st,
                                     logic [tehs_pkg::ID_W-1:0] id, logic last);
      fire_word_type w;
      w.status = st;
      w.id = id;
      w.now = clock_now;
      w.last = last;
      expected_words.push_back(w);
   endfunction

   // Work out the words one request causes
   function automatic void predict_request(logic op, logic [tehs_pkg::ID_W-1:0] id,
                                           logic [tehs_pkg::TIME_W-1:0] t);
      int hole;
      int n;
      int tail;
      logic [tehs_pkg::ID_W-1:0] fired;
      if (op == 1'b0) begin
         if (t <= clock_now || t == NEVER) begin
            push_word(tehs_pkg::ST_PAST, id, 1'b1);
         end else if (int'(id) >= ID_COUNT) begin
            push_word(tehs_pkg::ST_FULL, id, 1'b1);
         end else if (due_time[id] == NEVER && live >= QUEUE_DEPTH) begin
            push_word(tehs_pkg::ST_FULL, id, 1'b1);
         end else begin
            if (due_time[id] == NEVER) begin
               live++;
               hole = climb(live, t);
            end else begin
               hole = id_slot[id];
               if (hole == 1 || slot_key[hole/2] < t) hole = sink(hole, t);
               else hole = climb(hole, t);
            end
            place_entry(hole, id, t);
            due_time[id] = t;
            push_word(tehs_pkg::ST_OK, id, 1'b1);
         end
      end else if (live == 0) begin
         push_word(tehs_pkg::ST_EMPTY, '0, 1'b1);
      end else begin
         clock_now = slot_key[1];
         n = 0;
         while (live > 0 && slot_key[1] == clock_now && n < QUEUE_DEPTH) begin
            fired = slot_id[1];
            tail = live;
            due_time[fired] = NEVER;
            live--;
            if (live > 0) begin
               hole = sink(1, slot_key[tail]);
               place_entry(hole, slot_id[tail], slot_key[tail]);
            end
            push_word(tehs_pkg::ST_OK, fired, 1'b0);
            n++;
         end
         expected_words[$].last = 1'b1;
      end
   endfunction

   // Watch both channels
   always @(posedge clock) begin
      fire_word_type w;
      if (reset) begin
         for (int i = 0; i < tehs_pkg::ID_SLOTS; i++) due_time[i] = NEVER;
         live = 0;
         clock_now = '0;
         fail_count = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: id %0d status %0d", rsp_fired_id, rsp_status);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_status !== w.status) begin
                  $error("status: expected %0d, got %0d", w.status, rsp_status);
                  fail_count++;
               end
               if (rsp_fired_id !== w.id) begin
                  $error("fired_id: expected %0d, got %0d", w.id, rsp_fired_id);
                  fail_count++;
               end
               if (rsp_current_time !== w.now) begin
                  $error("current_time: expected %0h, got %0h", w.now, rsp_current_time);
                  fail_count++;
               end
               if (rsp_last_of_run !== w.last) begin
                  $error("last_of_run: expected %0b, got %0b", w.last, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_opcode, req_item_id, req_event_time);
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = 1'b0;
   logic [tehs_pkg::ID_W-1:0]   req_item_id = '0;
   logic [tehs_pkg::TIME_W-1:0] req_event_time = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [tehs_pkg::ST_W-1:0]   rsp_status;
   logic [tehs_pkg::ID_W-1:0]   rsp_fired_id;
   logic [tehs_pkg::TIME_W-1:0] rsp_current_time;
   logic                        rsp_last_of_run;
   int                          fail_count;
   int                          words_owed;

   int send_gap_pct;
   int stall_pct;

   // Sender's model of time, to aim schedule words just ahead of now
   logic [tehs_pkg::TIME_W-1:0] time_hint;

   always #10 clock = ~clock;

   timed_event_heap_scheduler dut (.*);

   heap_sched_checker chk (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_item_id,
      .req_event_time, .rsp_valid, .rsp_stall, .rsp_status, .rsp_fired_id,
      .rsp_current_time, .rsp_last_of_run, .fail_count, .words_owed
   );

   // Receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Track the latest time the block has reached
   always @(posedge clock)
      if (reset) time_hint <= '0;
      else if (rsp_valid && !rsp_stall) time_hint <= rsp_current_time;

   // Drive one word and hold it until taken; valid drops only when idling
   task automatic send_word(logic op, logic [tehs_pkg::ID_W-1:0] id,
                            logic [tehs_pkg::TIME_W-1:0] t);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_item_id <= id;
      req_event_time <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_word();
      int r;
      logic [tehs_pkg::TIME_W-1:0] t;
      r = $urandom_range(99);
      t = time_hint + $urandom_range(1, 12);
      if (r < 5) t = {$urandom, $urandom};
      else if (r < 8) t = time_hint - $urandom_range(0, 2);
      send_word(($urandom_range(99) < 28), 6'($urandom), t);
   endtask

   initial begin
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick, past time, field extremes, ties, reschedules
      send_word(1'b1, 6'd63, '1);
      send_word(1'b0, 6'd5, '0);
      send_word(1'b0, 6'd5, '1);
      send_word(1'b0, 6'd0, 64'd10);
      send_word(1'b0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFE);
      send_word(1'b0, 6'd21, 64'd10);
      send_word(1'b0, 6'd42, 64'd7);
      send_word(1'b0, 6'd42, 64'd30);
      send_word(1'b0, 6'd0, 64'd3);
      send_word(1'b0, 6'd63, 64'd2);
      send_word(1'b1, 6'd0, '0);
      send_word(1'b0, 6'd9, 64'd2);
      send_word(1'b1, 6'd0, '0);
      send_word(1'b1, 6'd0, '0);
      send_word(1'b1, 6'd0, '0);
      send_word(1'b1, 6'd0, '0);
      drain();

      // Directed: fill all 64 ids, overflow is impossible with only 64 ids;
      // then fire them all in one tick with a shared time
      for (int i = 0; i < 64; i++) send_word(1'b0, 6'(i), 64'd100);
      send_word(1'b0, 6'd17, 64'd100);
      send_word(1'b1, 6'd0, '0);
      drain();

      // Random phases with differing idling
      for (int ph = 0; ph < 4; ph++) begin
         send_gap_pct = (ph == 1 || ph == 3) ? 58 : 0;
         stall_pct    = (ph == 2) ? 58 : (ph == 3) ? 26 : 0;
         if (ph == 3) send_gap_pct = 26;
         for (int i = 0; i < 20; i++) random_word();
         drain();
      end
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (10) send_word(1'b1, 6'd0, '0);
      drain();

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
